[src/gmat_pkg.sv]
`default_nettype none
package gmat_pkg;

	localparam int unsigned MAX_SERVERS_DEF = 16;
	localparam int unsigned ID_W = 16;
	localparam int unsigned MEM_W = 12;
	localparam int unsigned NEED_W = 16;
	localparam int unsigned REQ_W = 3;
	localparam int unsigned ST_W = 3;
	localparam int unsigned BIT_W = 4;

	localparam logic [REQ_W-1:0] REQ_ADD = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_GREEDY = 3'd3;
	localparam logic [REQ_W-1:0] REQ_BALANCED = 3'd4;

	localparam logic [ST_W-1:0] ST_OK = 3'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL = 3'd3;
	localparam logic [ST_W-1:0] ST_NO_MEMORY = 3'd4;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [ID_W-1:0] node_id;
		logic [MEM_W-1:0] mem_size;
		logic [NEED_W-1:0] mem_request;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic [ID_W-1:0] granted_id;
		logic [MEM_W-1:0] granted_amount;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0] ident;
		logic [MEM_W-1:0] capacity;
		logic [MEM_W-1:0] in_use;
		logic online;
	} slot_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_FIND_RD, S_FIND_EV, S_ADD_CHK, S_DEL_CHK, S_DEL_RD,
		S_DEL_EV, S_SUM_RD, S_SUM_EV, S_SUM_CHK, S_BS_RD, S_BS_EV, S_BS_STEP,
		S_BAL_INIT, S_GR_RD, S_GR_EV, S_FLUSH, S_EMIT
	} ctrl_state_t;

	typedef enum logic [3:0] {
		DP_NOP, DP_LATCH, DP_NEXT, DP_TOGGLE, DP_ADD, DP_DEL_MOVE, DP_DEL_END,
		DP_SUM, DP_BS_INIT, DP_BS_ACC, DP_BS_STEP, DP_GR_INIT, DP_BAL_INIT,
		DP_GRANT, DP_FLUSH, DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [ST_W-1:0] emit_status;
	} dp_cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic match;
		logic last_slot;
		logic idx_at_cnt;
		logic cnt_zero;
		logic cnt_full;
		logic need_zero;
		logic short_mem;
		logic bit_zero;
		logic grant_nz;
		logic pend_valid;
		logic out_busy;
	} dp_status_t;

endpackage
`default_nettype wire

[src/gmat_chan_if.sv]
`default_nettype none
interface gmat_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[src/gmat_ctrl.sv]
`default_nettype none
module gmat_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire gmat_pkg::dp_status_t stat,
	output gmat_pkg::dp_cmd_t cmd,
	output logic in_ready
);
	import gmat_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [ST_W-1:0] st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				unique case (stat.req_type) inside
					REQ_ADD: state_d = stat.cnt_zero ? S_ADD_CHK : S_FIND_RD;
					REQ_DELETE, REQ_TOGGLE: begin
						if (stat.cnt_zero) begin
							state_d = S_EMIT;
							st_d = ST_NOT_FOUND;
						end else begin
							state_d = S_FIND_RD;
						end
					end
					REQ_GREEDY, REQ_BALANCED: begin
						if (stat.need_zero) begin
							state_d = S_EMIT;
							st_d = ST_OK;
						end else if (stat.cnt_zero) begin
							state_d = S_EMIT;
							st_d = ST_NO_MEMORY;
						end else begin
							state_d = S_SUM_RD;
						end
					end
					default: begin
						state_d = S_EMIT;
						st_d = ST_OK;
					end
				endcase
			end
			S_FIND_RD: state_d = S_FIND_EV;
			S_FIND_EV: begin
				if (stat.match) begin
					if (stat.req_type == REQ_ADD) begin
						state_d = S_EMIT;
						st_d = ST_DUPLICATE;
					end else if (stat.req_type == REQ_DELETE) begin
						state_d = S_DEL_CHK;
					end else begin
						state_d = S_EMIT;
						st_d = ST_OK;
					end
				end else if (stat.last_slot) begin
					if (stat.req_type == REQ_ADD) begin
						state_d = S_ADD_CHK;
					end else begin
						state_d = S_EMIT;
						st_d = ST_NOT_FOUND;
					end
				end else begin
					state_d = S_FIND_RD;
				end
			end
			S_ADD_CHK: begin
				state_d = S_EMIT;
				st_d = stat.cnt_full ? ST_FULL : ST_OK;
			end
			S_DEL_CHK: begin
				if (stat.idx_at_cnt) begin
					state_d = S_EMIT;
					st_d = ST_OK;
				end else begin
					state_d = S_DEL_RD;
				end
			end
			S_DEL_RD: state_d = S_DEL_EV;
			S_DEL_EV: state_d = S_DEL_CHK;
			S_SUM_RD: state_d = S_SUM_EV;
			S_SUM_EV: state_d = stat.last_slot ? S_SUM_CHK : S_SUM_RD;
			S_SUM_CHK: begin
				if (stat.short_mem) begin
					state_d = S_EMIT;
					st_d = ST_NO_MEMORY;
				end else if (stat.req_type == REQ_GREEDY) begin
					state_d = S_GR_RD;
				end else begin
					state_d = S_BS_RD;
				end
			end
			S_BS_RD: state_d = S_BS_EV;
			S_BS_EV: state_d = stat.last_slot ? S_BS_STEP : S_BS_RD;
			S_BS_STEP: state_d = stat.bit_zero ? S_BAL_INIT : S_BS_RD;
			S_BAL_INIT: state_d = S_GR_RD;
			S_GR_RD: state_d = S_GR_EV;
			S_GR_EV: begin
				if (!(stat.grant_nz && stat.pend_valid && stat.out_busy))
					state_d = stat.last_slot ? S_FLUSH : S_GR_RD;
			end
			S_FLUSH: if (!stat.out_busy) state_d = S_IDLE;
			S_EMIT: if (!stat.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = DP_NOP;
		cmd.emit_status = st_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = DP_LATCH;
			end
			S_FIND_EV: begin
				if (stat.match) begin
					if (stat.req_type == REQ_DELETE) cmd.op = DP_NEXT;
					else if (stat.req_type == REQ_TOGGLE) cmd.op = DP_TOGGLE;
				end else if (!stat.last_slot) begin
					cmd.op = DP_NEXT;
				end
			end
			S_ADD_CHK: if (!stat.cnt_full) cmd.op = DP_ADD;
			S_DEL_CHK: if (stat.idx_at_cnt) cmd.op = DP_DEL_END;
			S_DEL_EV: cmd.op = DP_DEL_MOVE;
			S_SUM_EV: cmd.op = DP_SUM;
			S_SUM_CHK: begin
				if (!stat.short_mem)
					cmd.op = (stat.req_type == REQ_GREEDY) ? DP_GR_INIT : DP_BS_INIT;
			end
			S_BS_EV: cmd.op = DP_BS_ACC;
			S_BS_STEP: cmd.op = DP_BS_STEP;
			S_BAL_INIT: cmd.op = DP_BAL_INIT;
			S_GR_EV: begin
				if (!(stat.grant_nz && stat.pend_valid && stat.out_busy)) cmd.op = DP_GRANT;
			end
			S_FLUSH: if (!stat.out_busy) cmd.op = DP_FLUSH;
			S_EMIT: if (!stat.out_busy) cmd.op = DP_EMIT;
			default: cmd.op = DP_NOP;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_LATCH) |=> (state_q == S_DISPATCH))
		else $error("latch did not start dispatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_EMIT || cmd.op == DP_FLUSH) |=> (state_q == S_IDLE))
		else $error("final result did not end the request");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> stat.pend_valid)
		else $error("flush without a pending grant");

endmodule
`default_nettype wire

[src/gmat_datapath.sv]
`default_nettype none
module gmat_datapath #(
	parameter int unsigned MAX_SERVERS = gmat_pkg::MAX_SERVERS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire gmat_pkg::req_t req_data,
	input wire gmat_pkg::dp_cmd_t cmd,
	input wire logic out_ready,
	output gmat_pkg::dp_status_t stat,
	output gmat_pkg::rsp_t out_data,
	output logic out_valid
);
	import gmat_pkg::*;

	localparam int unsigned IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int unsigned CW = $clog2(MAX_SERVERS + 1);
	localparam int unsigned TW = MEM_W + IW;
	localparam int unsigned KW = (TW > NEED_W) ? TW : NEED_W;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SERVERS);

	slot_t mem [MAX_SERVERS];
	slot_t rd_q;

	logic [CW-1:0] count_q, idx_q;
	req_t in_q;
	logic [TW-1:0] total_q, sacc_q, sl_q;
	logic [MEM_W-1:0] lvl_q;
	logic [BIT_W-1:0] bit_q;
	logic [NEED_W-1:0] rem_q;
	logic pend_valid_q;
	logic [ID_W-1:0] pend_id_q;
	logic [MEM_W-1:0] pend_amt_q;
	logic out_valid_q;
	rsp_t out_q;

	logic [MEM_W-1:0] room, trial, lvl_part, grant, extra_amt;
	logic extra;

	always_comb begin
		room = '0;
		if (rd_q.online && rd_q.capacity > rd_q.in_use) room = rd_q.capacity - rd_q.in_use;
		trial = lvl_q | (MEM_W'(1) << bit_q);
		lvl_part = (room < lvl_q) ? room : lvl_q;
		extra = (room > lvl_q) && (rem_q != '0);
		extra_amt = {{(MEM_W-1){1'b0}}, extra};
		if (in_q.req_type == REQ_GREEDY)
			grant = (rem_q >= NEED_W'(room)) ? room : rem_q[MEM_W-1:0];
		else
			grant = lvl_part + extra_amt;
	end

	always_comb begin
		stat.req_type = in_q.req_type;
		stat.match = (rd_q.ident == in_q.node_id);
		stat.last_slot = (idx_q == count_q - CW'(1));
		stat.idx_at_cnt = (idx_q == count_q);
		stat.cnt_zero = (count_q == '0);
		stat.cnt_full = (count_q == CNT_MAX);
		stat.need_zero = (in_q.mem_request == '0);
		stat.short_mem = (KW'(total_q) < KW'(in_q.mem_request));
		stat.bit_zero = (bit_q == '0);
		stat.grant_nz = (grant != '0);
		stat.pend_valid = pend_valid_q;
		stat.out_busy = out_valid_q;
	end

	// Single write port; the read port always follows the walk index.
	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q[IW-1:0]];
		case (cmd.op)
			DP_TOGGLE: mem[idx_q[IW-1:0]] <= '{rd_q.ident, rd_q.capacity, rd_q.in_use,
				~rd_q.online};
			DP_ADD: mem[count_q[IW-1:0]] <= '{in_q.node_id, in_q.mem_size, '0, 1'b1};
			DP_DEL_MOVE: mem[IW'(idx_q - CW'(1))] <= rd_q;
			DP_GRANT: mem[idx_q[IW-1:0]] <= '{rd_q.ident, rd_q.capacity,
				rd_q.in_use + grant, rd_q.online};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LATCH: in_q <= req_data;
			DP_SUM: total_q <= total_q + TW'(room);
			DP_BS_INIT: begin
				sacc_q <= '0;
				sl_q <= '0;
				lvl_q <= '0;
				bit_q <= BIT_W'(MEM_W - 1);
			end
			DP_BS_ACC: sacc_q <= sacc_q + TW'((room < trial) ? room : trial);
			DP_BS_STEP: begin
				if (KW'(sacc_q) <= KW'(in_q.mem_request)) begin
					lvl_q <= trial;
					sl_q <= sacc_q;
				end
				bit_q <= bit_q - BIT_W'(1);
				sacc_q <= '0;
			end
			DP_GR_INIT: rem_q <= in_q.mem_request;
			DP_BAL_INIT: rem_q <= in_q.mem_request - NEED_W'(sl_q);
			DP_GRANT: begin
				if (in_q.req_type == REQ_GREEDY) rem_q <= rem_q - NEED_W'(grant);
				else rem_q <= rem_q - NEED_W'(extra);
				if (grant != '0) begin
					pend_id_q <= rd_q.ident;
					pend_amt_q <= grant;
				end
			end
			default: ;
		endcase
		if (cmd.op == DP_LATCH) total_q <= '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_EMIT) out_q <= '{cmd.emit_status, '0, '0, 1'b1};
		else if (cmd.op == DP_FLUSH) out_q <= '{ST_OK, pend_id_q, pend_amt_q, 1'b1};
		else if (cmd.op == DP_GRANT && grant != '0 && pend_valid_q)
			out_q <= '{ST_OK, pend_id_q, pend_amt_q, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				DP_LATCH: begin
					idx_q <= '0;
					pend_valid_q <= 1'b0;
				end
				DP_NEXT, DP_DEL_MOVE, DP_SUM, DP_BS_ACC: idx_q <= idx_q + CW'(1);
				DP_ADD: count_q <= count_q + CW'(1);
				DP_DEL_END: count_q <= count_q - CW'(1);
				DP_BS_INIT, DP_BS_STEP, DP_GR_INIT, DP_BAL_INIT: idx_q <= '0;
				DP_GRANT: begin
					idx_q <= idx_q + CW'(1);
					if (grant != '0) begin
						pend_valid_q <= 1'b1;
						if (pend_valid_q) out_valid_q <= 1'b1;
					end
				end
				DP_FLUSH: begin
					pend_valid_q <= 1'b0;
					out_valid_q <= 1'b1;
				end
				DP_EMIT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign out_data = out_q;
	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_MAX)
		else $error("slot count beyond table size");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_ADD) |-> (count_q != CNT_MAX))
		else $error("add into a full table");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_EMIT || cmd.op == DP_FLUSH) |-> !out_valid_q)
		else $error("result register overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_GRANT && grant != '0 && pend_valid_q) |-> !out_valid_q)
		else $error("grant pushed into a busy result register");

endmodule
`default_nettype wire

[src/gpu_memory_allocation_table_unit.sv]
`default_nettype none
// Server memory allocation table with up to MAX_SERVERS slots held in one
// memory with a single write port and a registered read, walked slot by
// slot by a controller. A request is taken once the previous one has placed
// its final result in the output register. A delete shifts each later slot
// down by one; a balanced deploy searches the fill level bit by bit, twelve
// passes over the table. Each grant goes out as one transfer on the result
// channel, the last one marked; a stalled result channel holds the walk.
module gpu_memory_allocation_table_unit #(
	parameter int unsigned MAX_SERVERS = gmat_pkg::MAX_SERVERS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	gmat_chan_if.sink req,
	gmat_chan_if.source rsp
);
	import gmat_pkg::*;

	dp_cmd_t cmd;
	dp_status_t stat;

	gmat_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.stat(stat),
		.cmd(cmd),
		.in_ready(req.ready)
	);

	gmat_datapath #(.MAX_SERVERS(MAX_SERVERS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req_data(req.data),
		.cmd(cmd),
		.out_ready(rsp.ready),
		.stat(stat),
		.out_data(rsp.data),
		.out_valid(rsp.valid)
	);

endmodule
`default_nettype wire

[bench/gmat_table_predictor.sv]
`timescale 1ns / 100ps
`default_nettype none
package gmat_table_predictor;
	import gmat_pkg::*;

	localparam int unsigned TABLE_DEPTH = MAX_SERVERS_DEF;

	class server_table;
		logic [ID_W-1:0] ident[TABLE_DEPTH];
		logic [MEM_W-1:0] capacity[TABLE_DEPTH];
		logic [MEM_W-1:0] in_use[TABLE_DEPTH];
		bit online[TABLE_DEPTH];
		int unsigned count;

		function void clear();
			count = 0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				ident[i] = '0;
				capacity[i] = '0;
				in_use[i] = '0;
				online[i] = 1'b0;
			end
		endfunction

		function int find(logic [ID_W-1:0] id);
			for (int i = 0; i < count; i++)
				if (ident[i] == id)
					return i;
			return -1;
		endfunction

		// Applies one request and appends the results it should produce.
		function void apply(req_t r, ref rsp_t results[$]);
			rsp_t one;
			int pos;
			int unsigned room[TABLE_DEPTH];
			int unsigned grant[TABLE_DEPTH];
			int unsigned total;
			int unsigned need;
			int unsigned take;
			int unsigned given;
			one = '{status: ST_OK, granted_id: '0, granted_amount: '0, last: 1'b1};
			need = r.mem_request;
			case (r.req_type)
				REQ_ADD: begin
					if (find(r.node_id) >= 0)
						one.status = ST_DUPLICATE;
					else if (count >= TABLE_DEPTH)
						one.status = ST_FULL;
					else begin
						ident[count] = r.node_id;
						capacity[count] = r.mem_size;
						in_use[count] = '0;
						online[count] = 1'b1;
						count++;
					end
				end
				REQ_DELETE: begin
					pos = find(r.node_id);
					if (pos < 0)
						one.status = ST_NOT_FOUND;
					else begin
						for (int i = pos; i + 1 < count; i++) begin
							ident[i] = ident[i+1];
							capacity[i] = capacity[i+1];
							in_use[i] = in_use[i+1];
							online[i] = online[i+1];
						end
						count--;
					end
				end
				REQ_TOGGLE: begin
					pos = find(r.node_id);
					if (pos < 0)
						one.status = ST_NOT_FOUND;
					else
						online[pos] = !online[pos];
				end
				REQ_GREEDY, REQ_BALANCED: begin
					total = 0;
					for (int i = 0; i < count; i++) begin
						room[i] = (online[i] && capacity[i] > in_use[i]) ?
							capacity[i] - in_use[i] : 0;
						grant[i] = 0;
						total += room[i];
					end
					if (total < need)
						one.status = ST_NO_MEMORY;
					else if (r.req_type == REQ_GREEDY) begin
						for (int i = 0; i < count && need > 0; i++) begin
							take = (room[i] >= need) ? need : room[i];
							grant[i] = take;
							need -= take;
						end
					end else begin
						while (need > 0)
							for (int i = 0; i < count && need > 0; i++)
								if (grant[i] < room[i]) begin
									grant[i]++;
									need--;
								end
					end
					if (one.status == ST_OK) begin
						given = 0;
						for (int i = 0; i < count; i++)
							if (grant[i] > 0) begin
								in_use[i] = in_use[i] + grant[i][MEM_W-1:0];
								results.push_back('{status: ST_OK, granted_id: ident[i],
									granted_amount: grant[i][MEM_W-1:0], last: 1'b0});
								given++;
							end
						if (given > 0) begin
							results[$].last = 1'b1;
							return;
						end
					end
				end
				default: ;
			endcase
			results.push_back(one);
		endfunction
	endclass
endpackage
`default_nettype wire

[bench/gpu_memory_allocation_table_unit_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module gpu_memory_allocation_table_unit_test;
	import gmat_pkg::*;
	import gmat_table_predictor::*;

	logic clk;
	logic arst_n;
	gmat_chan_if #(.T(req_t)) req_ch();
	gmat_chan_if #(.T(rsp_t)) rsp_ch();

	gpu_memory_allocation_table_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	server_table table_model;
	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int unsigned error_count;
	bit stimulus_done;
	bit hold_sender;
	int unsigned gap_left;
	int unsigned burst_left;
	int unsigned stall_phase;
	logic [ID_W-1:0] used_ids[$];

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Request driver: bursts of random length separated by random gaps.
	// The accepted request leaves the queue first, so the head is always next.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				table_model.apply(req_ch.data, expected_rsps);
				void'(pending_reqs.pop_front());
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (gap_left > 0 || hold_sender) begin
					if (gap_left > 0)
						gap_left <= gap_left - 1;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req_ch.valid <= 1'b1;
					req_ch.data <= pending_reqs[0];
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
					end else
						burst_left <= burst_left - 1;
				end else
					req_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor with a stall pattern of its own.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result, actual %p", $realtime, rsp_ch.data);
					error_count++;
				end else begin
					rsp_t want;
					want = expected_rsps.pop_front();
					if (want.status !== rsp_ch.data.status ||
							want.granted_id !== rsp_ch.data.granted_id ||
							want.granted_amount !== rsp_ch.data.granted_amount ||
							want.last !== rsp_ch.data.last) begin
						$display("%0t: result mismatch, expected %p, actual %p",
							$realtime, want, rsp_ch.data);
						error_count++;
					end
				end
			end
			stall_phase <= (stall_phase + 1) % 96;
			if (stall_phase < 40)
				rsp_ch.ready <= 1'b1;
			else if (stall_phase < 64)
				rsp_ch.ready <= (stall_phase % 5) != 0;
			else
				rsp_ch.ready <= $urandom_range(0, 2) == 0;
		end
	end

	function automatic logic [ID_W-1:0] pick_id();
		if (used_ids.size() > 0 && $urandom_range(0, 3) != 0)
			return used_ids[$urandom_range(0, used_ids.size() - 1)];
		return ID_W'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40));
	endfunction

	function automatic req_t make_req(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
			logic [MEM_W-1:0] total, logic [NEED_W-1:0] need);
		req_t r;
		r.req_type = kind;
		r.node_id = id;
		r.mem_size = total;
		r.mem_request = need;
		if (kind == REQ_ADD)
			used_ids.push_back(id);
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		req_t r;
		int unsigned kind;
		int unsigned want;
		table_model = new();
		table_model.clear();
		error_count = 0;
		stimulus_done = 1'b0;
		hold_sender = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-table cases, extremes, full table, duplicates.
		pending_reqs.push_back(make_req(REQ_GREEDY, 16'h0, 12'h0, 16'd0));
		pending_reqs.push_back(make_req(REQ_BALANCED, 16'h0, 12'h0, 16'd1));
		pending_reqs.push_back(make_req(REQ_DELETE, 16'hFFFF, 12'hFFF, 16'hFFFF));
		pending_reqs.push_back(make_req(REQ_TOGGLE, 16'h1234, 12'h0, 16'h0));
		pending_reqs.push_back(make_req(3'd5, 16'hFFFF, 12'hFFF, 16'hFFFF));
		pending_reqs.push_back(make_req(3'd7, 16'h0, 12'h0, 16'h0));
		for (int i = 0; i < 16; i++)
			pending_reqs.push_back(make_req(REQ_ADD, (i == 15) ? 16'hFFFF : 16'(i),
				(i == 0) ? 12'hFFF : (i == 1) ? 12'h0 : 12'(3 + i), 16'h0));
		pending_reqs.push_back(make_req(REQ_ADD, 16'd77, 12'd5, 16'd0));
		pending_reqs.push_back(make_req(REQ_ADD, 16'd3, 12'd5, 16'd0));
		pending_reqs.push_back(make_req(REQ_BALANCED, 16'h0, 12'h0, 16'd4300));
		pending_reqs.push_back(make_req(REQ_GREEDY, 16'h0, 12'h0, 16'hFFFF));
		pending_reqs.push_back(make_req(REQ_TOGGLE, 16'd2, 12'h0, 16'h0));
		pending_reqs.push_back(make_req(REQ_GREEDY, 16'h0, 12'h0, 16'd50));
		pending_reqs.push_back(make_req(REQ_DELETE, 16'd0, 12'h0, 16'h0));
		used_ids.delete(0);

		wait_drained();
		// Hold off until every expected result is in.
		hold_sender = 1'b1;
		wait_drained();
		hold_sender = 1'b0;

		for (int n = 0; n < 280; n++) begin
			kind = $urandom_range(0, 99);
			want = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300);
			if (kind < 30)
				r = make_req(REQ_ADD, pick_id(), ($urandom_range(0, 5) == 0) ?
					MEM_W'($urandom) : MEM_W'($urandom_range(0, 200)), NEED_W'($urandom));
			else if (kind < 45)
				r = make_req(REQ_DELETE, pick_id(), MEM_W'($urandom), NEED_W'($urandom));
			else if (kind < 57)
				r = make_req(REQ_TOGGLE, pick_id(), MEM_W'($urandom), NEED_W'($urandom));
			else if (kind < 77)
				r = make_req(REQ_GREEDY, ID_W'($urandom), MEM_W'($urandom), NEED_W'(want));
			else if (kind < 97)
				r = make_req(REQ_BALANCED, ID_W'($urandom), MEM_W'($urandom), NEED_W'(want));
			else
				r = make_req(REQ_W'($urandom_range(5, 7)), ID_W'($urandom), MEM_W'($urandom),
					NEED_W'($urandom));
			pending_reqs.push_back(r);
			if (n == 150) begin
				wait_drained();
				hold_sender = 1'b1;
				wait_drained();
				hold_sender = 1'b0;
			end
		end
		wait_drained();
		repeat (600) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#8000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
